### src/ffd_pkg.sv
// ----------------------------------------------------------------------------
// ffd_pkg
// Shared codes for the free frame deque: operations, status and sequencer
// states.
// ----------------------------------------------------------------------------
package ffd_pkg;

    typedef enum logic [2:0] {
        OP_PUSH_BACK  = 3'd0,
        OP_PUSH_FRONT = 3'd1,
        OP_TAKE_BACK  = 3'd2,
        OP_TAKE_FRONT = 3'd3,
        OP_REMOVE     = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_EMPTY     = 2'd1,
        STAT_NOT_FOUND = 2'd2,
        STAT_DUPLICATE = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOK,
        ST_WAIT,
        ST_WRITE,
        ST_FINISH
    } state_t;

    localparam int unsigned OP_W     = 3;
    localparam int unsigned ID_W     = 10;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned TOTAL_W  = 11;
    // wide enough to compare any frame number against the frame count
    localparam int unsigned CMP_W    = 17;
    // write words queued per operation
    localparam int unsigned WQ_DEPTH = 3;

endpackage

### src/ffd_cell.sv
// ----------------------------------------------------------------------------
// ffd_cell
// One bank of the link store. Owns every frame whose low address bits match
// its index, applies writes to its bank and fills in the read fields of a
// lookup word, then hands the word to its neighbor in the next cycle.
// ----------------------------------------------------------------------------
module ffd_cell #(
    parameter int unsigned CELL_IDX  = 0,
    parameter int unsigned CELL_BITS = 2,
    parameter int unsigned FW        = 10,
    parameter int unsigned LW        = 11
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic [FW+2*LW+5:0]        word_i,
    output logic [FW+2*LW+5:0]        word_o
);

    localparam int unsigned IW    = FW - CELL_BITS;
    localparam int unsigned DEPTH = 1 << IW;

    typedef struct packed {
        logic          vld;
        logic          look;
        logic [FW-1:0] addr;
        logic          we_nxt;
        logic          we_prv;
        logic          we_mem;
        logic [LW-1:0] nxt_link;
        logic [LW-1:0] prv_link;
        logic          mem_bit;
    } chain_word_t;

    chain_word_t in_w;
    chain_word_t out_w;
    chain_word_t word_reg;
    chain_word_t word_next;

    logic [LW-1:0] nxt_mem    [DEPTH];
    logic [LW-1:0] prv_mem    [DEPTH];
    logic          member_mem [DEPTH];

    logic [LW-1:0] nxt_rd_reg;
    logic [LW-1:0] prv_rd_reg;
    logic          mem_rd_reg;
    logic          vld_reg;
    logic          vld_next;
    logic          look_hit_reg;
    logic          look_hit_next;

    logic          own;
    logic          hit;
    logic [IW-1:0] idx;

    assign in_w      = chain_word_t'(word_i);
    assign own       = (in_w.addr[CELL_BITS-1:0] == CELL_BITS'(CELL_IDX));
    assign hit       = in_w.vld && own;
    assign idx       = in_w.addr[FW-1:CELL_BITS];
    assign word_next = in_w;
    assign vld_next  = in_w.vld;
    assign look_hit_next = hit && in_w.look;

    always_ff @(posedge aclk) begin
        if (hit && in_w.we_nxt) begin
            nxt_mem[idx] <= in_w.nxt_link;
        end
        if (hit && in_w.we_prv) begin
            prv_mem[idx] <= in_w.prv_link;
        end
        if (hit && in_w.we_mem) begin
            member_mem[idx] <= in_w.mem_bit;
        end
        nxt_rd_reg <= nxt_mem[idx];
        prv_rd_reg <= prv_mem[idx];
        mem_rd_reg <= member_mem[idx];
    end

    always_ff @(posedge aclk) begin
        word_reg <= word_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg      <= 1'b0;
            look_hit_reg <= 1'b0;
        end else begin
            vld_reg      <= vld_next;
            look_hit_reg <= look_hit_next;
        end
    end

    // fill in the read fields only in the bank that owns the looked-up frame
    always_comb begin
        out_w     = word_reg;
        out_w.vld = vld_reg;
        if (look_hit_reg) begin
            out_w.nxt_link = nxt_rd_reg;
            out_w.prv_link = prv_rd_reg;
            out_w.mem_bit  = mem_rd_reg;
        end
    end

    assign word_o = out_w;

endmodule

### src/free_frame_deque.sv
// ----------------------------------------------------------------------------
// free_frame_deque
// Ordered list of free frame numbers kept as a doubly linked list. The link
// and membership store is split over a row of banked cells; a sequencer sends
// lookup and write words down the row and keeps the front, back and count.
// ----------------------------------------------------------------------------
//
//  channel   | direction | tdata fields (lowest bit first)
//  ----------+-----------+--------------------------------------------------
//  s_        | in        | op[2:0], item_id[12:3]
//  m_        | out       | taken_id[9:0], status[11:10], entry_total[22:12],
//            |           | front_id[32:23], is_empty[33]
//
//  Per word: lookup, wait while it passes the row, three write slots,
//  result load, idle; the next word is accepted only back in idle. After
//  reset the row clears the membership bits, one frame per cycle, for
//  every frame with s_tready low. A waiting result does not block input;
//  only the result load holds for m_. NUM_CELLS is a power of two of at
//  least 2, and NUM_FRAMES >= 2*NUM_CELLS.
//
module free_frame_deque #(
    parameter int unsigned NUM_FRAMES = 1024,
    parameter int unsigned NUM_CELLS  = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // op[2:0], item_id[12:3]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata    // taken_id, status, entry_total, front_id, is_empty
);

    localparam int unsigned FW        = $clog2(NUM_FRAMES);
    localparam int unsigned LW        = $clog2(NUM_FRAMES + 1);
    localparam int unsigned CELL_BITS = $clog2(NUM_CELLS);
    localparam int unsigned WORD_W    = FW + 2*LW + 6;
    localparam logic [LW-1:0] NULL_LINK = LW'(NUM_FRAMES);
    localparam logic [FW-1:0] LAST_FRAME = FW'(NUM_FRAMES - 1);

    typedef struct packed {
        logic          vld;
        logic          look;
        logic [FW-1:0] addr;
        logic          we_nxt;
        logic          we_prv;
        logic          we_mem;
        logic [LW-1:0] nxt_link;
        logic [LW-1:0] prv_link;
        logic          mem_bit;
    } chain_word_t;

    ffd_pkg::state_t state_reg, state_next;

    logic [ffd_pkg::OP_W-1:0]     op_reg, op_next;
    logic [ffd_pkg::ID_W-1:0]     id_reg, id_next;
    logic                         id_ok_reg, id_ok_next;
    logic [FW-1:0]                clr_cnt_reg, clr_cnt_next;
    logic [LW-1:0]                front_reg, front_next;
    logic [LW-1:0]                back_reg, back_next;
    logic [LW-1:0]                count_reg, count_next;
    logic [1:0]                   wr_cnt_reg, wr_cnt_next;
    chain_word_t                  wq_reg  [ffd_pkg::WQ_DEPTH];
    chain_word_t                  wq_next [ffd_pkg::WQ_DEPTH];
    logic [ffd_pkg::ID_W-1:0]     taken_reg, taken_next;
    ffd_pkg::status_t             status_reg, status_next;
    logic                         m_tvalid_reg, m_tvalid_next;
    logic [39:0]                  m_tdata_reg, m_tdata_next;

    logic [WORD_W-1:0] chain_w [NUM_CELLS+1];
    chain_word_t       issue_w;
    chain_word_t       ret_w;
    logic              ret_hit;
    logic              s_accept;
    logic              out_free;
    logic              front_ok;

    // ---- cell row ----
    assign chain_w[0] = issue_w;

    for (genvar gi = 0; gi < NUM_CELLS; gi++) begin : g_cell
        ffd_cell #(
            .CELL_IDX (gi),
            .CELL_BITS(CELL_BITS),
            .FW       (FW),
            .LW       (LW)
        ) u_cell (
            .aclk   (aclk),
            .aresetn(aresetn),
            .word_i (chain_w[gi]),
            .word_o (chain_w[gi+1])
        );
    end

    assign ret_w    = chain_word_t'(chain_w[NUM_CELLS]);
    assign ret_hit  = ret_w.vld && ret_w.look;
    assign s_tready = (state_reg == ffd_pkg::ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign front_ok = (count_reg != '0) && (front_reg < NULL_LINK);

    // ---- next state ----
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ffd_pkg::ST_CLEAR: begin
                if (clr_cnt_reg == LAST_FRAME) state_next = ffd_pkg::ST_IDLE;
            end
            ffd_pkg::ST_IDLE: begin
                if (s_accept) state_next = ffd_pkg::ST_LOOK;
            end
            ffd_pkg::ST_LOOK: begin
                state_next = ffd_pkg::ST_WAIT;
            end
            ffd_pkg::ST_WAIT: begin
                if (ret_hit) state_next = ffd_pkg::ST_WRITE;
            end
            ffd_pkg::ST_WRITE: begin
                if (wr_cnt_reg == 2'(ffd_pkg::WQ_DEPTH - 1)) state_next = ffd_pkg::ST_FINISH;
            end
            ffd_pkg::ST_FINISH: begin
                if (out_free) state_next = ffd_pkg::ST_IDLE;
            end
            default: state_next = ffd_pkg::ST_CLEAR;
        endcase
    end

    // ---- word issued into the row ----
    always_comb begin
        issue_w = '0;
        case (state_reg)
            ffd_pkg::ST_CLEAR: begin
                issue_w.vld     = 1'b1;
                issue_w.addr    = clr_cnt_reg;
                issue_w.we_mem  = 1'b1;
                issue_w.mem_bit = 1'b0;
            end
            ffd_pkg::ST_LOOK: begin
                issue_w.vld  = 1'b1;
                issue_w.look = 1'b1;
                if (op_reg == ffd_pkg::OP_TAKE_BACK) begin
                    issue_w.addr = FW'(back_reg);
                end else if (op_reg == ffd_pkg::OP_TAKE_FRONT) begin
                    issue_w.addr = FW'(front_reg);
                end else begin
                    issue_w.addr = FW'(id_reg);
                end
            end
            ffd_pkg::ST_WRITE: begin
                issue_w = wq_reg[0];
            end
            default: issue_w = '0;
        endcase
    end

    // ---- datapath ----
    always_comb begin
        logic [LW-1:0] unl_f;
        logic          do_unlink;

        op_next       = op_reg;
        id_next       = id_reg;
        id_ok_next    = id_ok_reg;
        clr_cnt_next  = clr_cnt_reg;
        front_next    = front_reg;
        back_next     = back_reg;
        count_next    = count_reg;
        wr_cnt_next   = wr_cnt_reg;
        taken_next    = taken_reg;
        status_next   = status_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        unl_f         = '0;
        do_unlink     = 1'b0;

        // advance the write queue one slot per issue cycle
        wq_next[0] = wq_reg[1];
        wq_next[1] = wq_reg[2];
        wq_next[2] = '0;

        if (m_tvalid_reg && m_tready) m_tvalid_next = 1'b0;

        case (state_reg)
            ffd_pkg::ST_CLEAR: begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
            end
            ffd_pkg::ST_IDLE: begin
                if (s_accept) begin
                    op_next    = s_tdata[2:0];
                    id_next    = s_tdata[12:3];
                    id_ok_next = (ffd_pkg::CMP_W'(s_tdata[12:3])
                                  < ffd_pkg::CMP_W'(NUM_FRAMES));
                end
            end
            ffd_pkg::ST_WAIT: begin
                if (ret_hit) begin
                    wq_next[0]  = '0;
                    wq_next[1]  = '0;
                    wq_next[2]  = '0;
                    wr_cnt_next = '0;
                    taken_next  = '0;
                    status_next = ffd_pkg::STAT_OK;
                    case (op_reg)
                        ffd_pkg::OP_PUSH_BACK, ffd_pkg::OP_PUSH_FRONT: begin
                            if (!id_ok_reg) begin
                                status_next = ffd_pkg::STAT_NOT_FOUND;
                            end else if (ret_w.mem_bit) begin
                                status_next = ffd_pkg::STAT_DUPLICATE;
                            end else begin
                                wq_next[0].vld     = 1'b1;
                                wq_next[0].addr    = FW'(id_reg);
                                wq_next[0].we_nxt  = 1'b1;
                                wq_next[0].we_prv  = 1'b1;
                                wq_next[0].we_mem  = 1'b1;
                                wq_next[0].mem_bit = 1'b1;
                                count_next = count_reg + 1'b1;
                                if (op_reg == ffd_pkg::OP_PUSH_BACK) begin
                                    wq_next[0].prv_link = back_reg;
                                    wq_next[0].nxt_link = NULL_LINK;
                                    if (back_reg < NULL_LINK) begin
                                        wq_next[1].vld      = 1'b1;
                                        wq_next[1].addr     = FW'(back_reg);
                                        wq_next[1].we_nxt   = 1'b1;
                                        wq_next[1].nxt_link = LW'(id_reg);
                                    end else begin
                                        front_next = LW'(id_reg);
                                    end
                                    back_next = LW'(id_reg);
                                end else begin
                                    wq_next[0].nxt_link = front_reg;
                                    wq_next[0].prv_link = NULL_LINK;
                                    if (front_reg < NULL_LINK) begin
                                        wq_next[1].vld      = 1'b1;
                                        wq_next[1].addr     = FW'(front_reg);
                                        wq_next[1].we_prv   = 1'b1;
                                        wq_next[1].prv_link = LW'(id_reg);
                                    end else begin
                                        back_next = LW'(id_reg);
                                    end
                                    front_next = LW'(id_reg);
                                end
                            end
                        end
                        ffd_pkg::OP_TAKE_BACK: begin
                            if (count_reg == '0 || !(back_reg < NULL_LINK)) begin
                                status_next = ffd_pkg::STAT_EMPTY;
                            end else begin
                                unl_f     = back_reg;
                                do_unlink = 1'b1;
                            end
                        end
                        ffd_pkg::OP_TAKE_FRONT: begin
                            if (count_reg == '0 || !(front_reg < NULL_LINK)) begin
                                status_next = ffd_pkg::STAT_EMPTY;
                            end else begin
                                unl_f     = front_reg;
                                do_unlink = 1'b1;
                            end
                        end
                        ffd_pkg::OP_REMOVE: begin
                            if (!id_ok_reg || !ret_w.mem_bit) begin
                                status_next = ffd_pkg::STAT_NOT_FOUND;
                            end else begin
                                unl_f     = LW'(id_reg);
                                do_unlink = 1'b1;
                            end
                        end
                        default: status_next = ffd_pkg::STAT_OK;
                    endcase

                    // splice the frame out between its looked-up neighbors
                    if (do_unlink) begin
                        taken_next         = ffd_pkg::ID_W'(unl_f);
                        wq_next[0].vld     = 1'b1;
                        wq_next[0].addr    = FW'(unl_f);
                        wq_next[0].we_mem  = 1'b1;
                        wq_next[0].mem_bit = 1'b0;
                        if (ret_w.prv_link < NULL_LINK) begin
                            wq_next[1].vld      = 1'b1;
                            wq_next[1].addr     = FW'(ret_w.prv_link);
                            wq_next[1].we_nxt   = 1'b1;
                            wq_next[1].nxt_link = ret_w.nxt_link;
                        end else begin
                            front_next = ret_w.nxt_link;
                        end
                        if (ret_w.nxt_link < NULL_LINK) begin
                            wq_next[2].vld      = 1'b1;
                            wq_next[2].addr     = FW'(ret_w.nxt_link);
                            wq_next[2].we_prv   = 1'b1;
                            wq_next[2].prv_link = ret_w.prv_link;
                        end else begin
                            back_next = ret_w.prv_link;
                        end
                        if (count_reg != '0) count_next = count_reg - 1'b1;
                    end
                end
            end
            ffd_pkg::ST_WRITE: begin
                wr_cnt_next = wr_cnt_reg + 1'b1;
            end
            ffd_pkg::ST_FINISH: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {6'b0,
                                     (count_reg == '0),
                                     front_ok ? ffd_pkg::ID_W'(front_reg)
                                              : ffd_pkg::ID_W'(0),
                                     ffd_pkg::TOTAL_W'(count_reg),
                                     status_reg,
                                     taken_reg};
                end
            end
            default: clr_cnt_next = clr_cnt_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ffd_pkg::ST_CLEAR;
            clr_cnt_reg  <= '0;
            front_reg    <= NULL_LINK;
            back_reg     <= NULL_LINK;
            count_reg    <= '0;
            wr_cnt_reg   <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_cnt_reg  <= clr_cnt_next;
            front_reg    <= front_next;
            back_reg     <= back_next;
            count_reg    <= count_next;
            wr_cnt_reg   <= wr_cnt_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg      <= op_next;
        id_reg      <= id_next;
        id_ok_reg   <= id_ok_next;
        wq_reg      <= wq_next;
        taken_reg   <= taken_next;
        status_reg  <= status_next;
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // ---- checks ----
    a_accept_starts_lookup: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> state_reg == ffd_pkg::ST_LOOK)
        else $error("accepted word did not start a lookup");

    a_lookup_returns_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        ret_hit |-> state_reg == ffd_pkg::ST_WAIT)
        else $error("lookup word returned outside the wait step");

    a_count_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= LW'(NUM_FRAMES))
        else $error("entry count above frame count");

    a_empty_has_null_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ffd_pkg::ST_IDLE && count_reg == '0)
            |-> (front_reg == NULL_LINK && back_reg == NULL_LINK))
        else $error("empty list with a live front or back");

endmodule
